@@ sv/lpi_pkg.sv @@
// ----------------------------------------------------------------------------
// lpi_pkg
// shared widths, register indexes and controller/datapath command types
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int COORD_W       = 32;
    localparam int STEP_LEN_W    = 31;
    localparam int TIME_W        = 20;
    localparam int ACC_W         = 48;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int MAX_STEPS_DEF = 64;

    // derived arithmetic widths
    localparam int MAG_W  = COORD_W;          // |target - cur| never reaches 2^32
    localparam int SUM_W  = 2 * MAG_W + 2;    // sum of three squares
    localparam int LEN_W  = SUM_W / 2;        // integer square root
    localparam int STEP_W = STEP_LEN_W + 1;   // step after optional doubling
    localparam int DEN_W  = LEN_W + TIME_W;   // length * step time

    localparam logic [TIME_W-1:0]     US_PER_S       = TIME_W'(1000000);
    localparam logic [STEP_LEN_W-1:0] STEP_LEN_RESET = STEP_LEN_W'(131072);
    localparam logic [TIME_W-1:0]     TIME_RESET     = TIME_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LEN = 3'd0,
        CFG_TIME     = 3'd1,
        CFG_ORIGIN_X = 3'd2,
        CFG_ORIGIN_Y = 3'd3,
        CFG_ORIGIN_Z = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_START,
        DP_LOAD,
        DP_SQ,
        DP_SQRT,
        DP_LSET,
        DP_NDIV,
        DP_NSET,
        DP_PDIV,
        DP_PSET,
        DP_VMUL,
        DP_VMUL2,
        DP_XDIV,
        DP_VSET,
        DP_AMUL,
        DP_AMUL2,
        DP_AMUL3,
        DP_ASET,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic short_seg;
        logic more;
    } dp_stat_t;

endpackage

@@ sv/lpi_div.sv @@
// ----------------------------------------------------------------------------
// lpi_div
// restoring divider, one quotient bit per cycle, quotient shifts into the
// dividend register
// ----------------------------------------------------------------------------
module lpi_div #(
    parameter int NUM_W = 92,
    parameter int DEN_W = 53
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic             done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_next;

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[NUM_W-2:0], ge};
                rem_reg <= rem_next[DEN_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = num_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

@@ sv/lpi_sqrt.sv @@
// ----------------------------------------------------------------------------
// lpi_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module lpi_sqrt #(
    parameter int RAD_W = 66
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RAD_W-1:0]   rad,
    output logic [RAD_W/2-1:0] root,
    output logic               done
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_next;

    assign rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_next = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
                rad_reg  <= rad;
                root_reg <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                rem_reg  <= rem_next[REM_W-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

@@ sv/lpi_datapath.sv @@
// ----------------------------------------------------------------------------
// lpi_datapath
// configuration, path state, dedicated multipliers, shared divider and square root,
// per-step position accumulators and the result register
// ----------------------------------------------------------------------------
module lpi_datapath #(
    parameter int MAX_STEPS = lpi_pkg::MAX_STEPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [lpi_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_x,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_y,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_z,
    input  logic                                 s_double_step,
    input  logic                                 s_drop_final,
    input  lpi_pkg::dp_cmd_t                     cmd,
    output lpi_pkg::dp_stat_t                    stat,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_x,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_y,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_z,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_x,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_y,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_z,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_x,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_y,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_z,
    output logic                                 m_last_of_run
);
    import lpi_pkg::*;

    localparam int N_W   = $clog2(MAX_STEPS + 1);
    localparam int DV_W  = COORD_W + 1;
    localparam int NUM_W = DV_W + STEP_W + N_W + TIME_W;

    localparam logic [NUM_W-1:0] VEL_POS = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] VEL_NEG = NUM_W'(64'h8000_0000);
    localparam logic [NUM_W-1:0] ACC_POS = NUM_W'(64'h7FFF_FFFF_FFFF);
    localparam logic [NUM_W-1:0] ACC_NEG = NUM_W'(64'h8000_0000_0000);

    // configuration
    logic [STEP_LEN_W-1:0]     step_len_reg;
    logic [TIME_W-1:0]         time_reg;
    logic signed [COORD_W-1:0] origin_reg [3];

    // path state
    logic signed [COORD_W-1:0] cur_reg    [3];
    logic signed [COORD_W-1:0] base_reg   [3];
    logic [MAG_W-1:0]          mag_reg    [3];
    logic                      neg_reg    [3];
    logic signed [COORD_W-1:0] vel_reg    [3];
    logic signed [COORD_W-1:0] prev_reg   [3];
    logic signed [ACC_W-1:0]   acc_reg    [3];
    logic                      dvneg_reg  [3];
    logic [MAG_W-1:0]          qd_reg     [3];
    logic [N_W-1:0]            rd_reg     [3];
    logic [MAG_W-1:0]          q_reg      [3];
    logic [N_W-1:0]            r_reg      [3];

    logic [STEP_W-1:0]         step_reg;
    logic [TIME_W-1:0]         t_reg;
    logic                      drop_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [N_W-1:0]            n_reg;
    logic [N_W-1:0]            count_reg;
    logic [N_W-1:0]            i_reg;
    logic [NUM_W-1:0]          prod_reg;

    // result register
    logic signed [COORD_W-1:0] out_pos_reg [3];
    logic signed [COORD_W-1:0] out_vel_reg [3];
    logic signed [ACC_W-1:0]   out_acc_reg [3];
    logic                      out_last_reg;

    // shared units
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [NUM_W-1:0]          div_quo;
    logic [DEN_W-1:0]          div_rem;
    logic                      div_done;
    logic [LEN_W-1:0]          sqrt_root;
    logic                      sqrt_done;

    // full-width products
    logic [2*MAG_W-1:0]                 sq_prod;
    logic [MAG_W+STEP_W-1:0]            vm_prod;
    logic [MAG_W+STEP_W+TIME_W-1:0]     vm2_prod;
    logic [DV_W+STEP_W-1:0]             am_prod;
    logic [DV_W+STEP_W+N_W-1:0]         am2_prod;
    logic [NUM_W-1:0]                   am3_prod;
    logic [DEN_W-1:0]                   den_prod;

    logic signed [COORD_W-1:0] tgt        [3];
    logic signed [DV_W-1:0]    d_next     [3];
    logic [STEP_LEN_W-1:0]     step_base;
    logic [TIME_W-1:0]         t_eff;
    logic signed [DV_W-1:0]    dv;
    logic [DV_W-1:0]           dv_mag;
    logic [NUM_W-1:0]          sat_lim;
    logic [ACC_W-1:0]          sat_mag;
    logic [N_W:0]              rs         [3];
    logic                      wrap       [3];
    logic [MAG_W-1:0]          q_next     [3];
    logic [N_W-1:0]            i_next;
    logic [1:0]                ax;

    assign ax  = cmd.axis;
    assign tgt = '{s_target_x, s_target_y, s_target_z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k] = DV_W'(tgt[k]) - DV_W'(cur_reg[k]);
            rs[k]     = {1'b0, r_reg[k]} + {1'b0, rd_reg[k]};
            wrap[k]   = rs[k] >= {1'b0, n_reg};
            q_next[k] = q_reg[k] + qd_reg[k] + MAG_W'(wrap[k]);
        end
    end

    assign step_base = (step_len_reg == '0) ? STEP_LEN_W'(1) : step_len_reg;
    assign t_eff     = (time_reg == '0) ? TIME_W'(1) : time_reg;
    assign dv        = DV_W'(vel_reg[ax]) - DV_W'(prev_reg[ax]);
    assign dv_mag    = dv[DV_W-1] ? DV_W'(-dv) : DV_W'(dv);
    assign i_next    = i_reg + 1'b1;

    assign sq_prod  = mag_reg[ax] * mag_reg[ax];
    assign vm_prod  = mag_reg[ax] * step_reg;
    assign vm2_prod = prod_reg[MAG_W+STEP_W-1:0] * US_PER_S;
    assign am_prod  = dv_mag * step_reg;
    assign am2_prod = prod_reg[DV_W+STEP_W-1:0] * n_reg;
    assign am3_prod = prod_reg[DV_W+STEP_W+N_W-1:0] * US_PER_S;
    assign den_prod = sqrt_root * t_reg;

    // saturation limit for the sign in hand
    always_comb begin
        case (cmd.op)
            DP_VSET: sat_lim = neg_reg[ax] ? VEL_NEG : VEL_POS;
            default: sat_lim = dvneg_reg[ax] ? ACC_NEG : ACC_POS;
        endcase
        sat_mag = (div_quo > sat_lim) ? sat_lim[ACC_W-1:0] : div_quo[ACC_W-1:0];
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = den_reg;
        case (cmd.op)
            DP_NDIV: begin
                div_start = 1'b1;
                div_num   = NUM_W'(len_reg);
                div_den   = DEN_W'(step_reg);
            end
            DP_PDIV: begin
                div_start = 1'b1;
                div_num   = NUM_W'(mag_reg[ax]);
                div_den   = DEN_W'(n_reg);
            end
            DP_XDIV: div_start = 1'b1;
            default: ;
        endcase
    end

    lpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .rem     (div_rem),
        .done    (div_done)
    );

    lpi_sqrt #(.RAD_W(SUM_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == DP_SQRT),
        .rad     (sum_reg),
        .root    (sqrt_root),
        .done    (sqrt_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_len_reg <= STEP_LEN_RESET;
            time_reg     <= TIME_RESET;
            origin_reg   <= '{default: '0};
            cur_reg      <= '{default: '0};
            prev_reg     <= '{default: '0};
            i_reg        <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_STEP_LEN: step_len_reg  <= cfg_wdata[STEP_LEN_W-1:0];
                    CFG_TIME:     time_reg      <= cfg_wdata[TIME_W-1:0];
                    CFG_ORIGIN_X: origin_reg[0] <= cfg_wdata;
                    CFG_ORIGIN_Y: origin_reg[1] <= cfg_wdata;
                    CFG_ORIGIN_Z: origin_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end

            case (cmd.op)
                DP_START: begin
                    cur_reg      <= origin_reg;
                    prev_reg     <= '{default: '0};
                    out_pos_reg  <= origin_reg;
                    out_vel_reg  <= '{default: '0};
                    out_acc_reg  <= '{default: '0};
                    out_last_reg <= 1'b1;
                    // the single word is already in the result register
                    i_reg        <= N_W'(1);
                    count_reg    <= N_W'(1);
                end
                DP_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        base_reg[k] <= cur_reg[k];
                        cur_reg[k]  <= tgt[k];
                        neg_reg[k]  <= d_next[k][DV_W-1];
                        mag_reg[k]  <= d_next[k][DV_W-1] ? MAG_W'(-d_next[k])
                                                          : MAG_W'(d_next[k]);
                    end
                    step_reg <= s_double_step ? {step_base, 1'b0} : {1'b0, step_base};
                    t_reg    <= t_eff;
                    drop_reg <= s_drop_final;
                end
                DP_SQ: begin
                    sum_reg <= ((ax == 2'd0) ? '0 : sum_reg) + SUM_W'(sq_prod);
                end
                DP_LSET: begin
                    len_reg <= sqrt_root;
                    den_reg <= den_prod;
                end
                DP_NSET: begin
                    if (div_quo == '0) begin
                        n_reg     <= N_W'(1);
                        count_reg <= drop_reg ? N_W'(0) : N_W'(1);
                    end else if (div_quo > NUM_W'(MAX_STEPS)) begin
                        n_reg     <= N_W'(MAX_STEPS);
                        count_reg <= drop_reg ? N_W'(MAX_STEPS - 1) : N_W'(MAX_STEPS);
                    end else begin
                        n_reg     <= div_quo[N_W-1:0];
                        count_reg <= drop_reg ? div_quo[N_W-1:0] - 1'b1 : div_quo[N_W-1:0];
                    end
                    i_reg <= '0;
                    q_reg <= '{default: '0};
                    r_reg <= '{default: '0};
                end
                DP_PSET: begin
                    qd_reg[ax] <= div_quo[MAG_W-1:0];
                    rd_reg[ax] <= div_rem[N_W-1:0];
                end
                DP_VMUL:  prod_reg <= NUM_W'(vm_prod);
                DP_VMUL2: prod_reg <= NUM_W'(vm2_prod);
                DP_VSET: begin
                    vel_reg[ax] <= neg_reg[ax] ? COORD_W'(-sat_mag[COORD_W-1:0])
                                               : sat_mag[COORD_W-1:0];
                end
                DP_AMUL: begin
                    dvneg_reg[ax] <= dv[DV_W-1];
                    prod_reg      <= NUM_W'(am_prod);
                end
                DP_AMUL2: prod_reg <= NUM_W'(am2_prod);
                DP_AMUL3: begin
                    prod_reg <= am3_prod;
                end
                DP_ASET: begin
                    acc_reg[ax] <= dvneg_reg[ax] ? ACC_W'(-sat_mag) : sat_mag;
                end
                DP_EMIT: begin
                    for (int k = 0; k < 3; k++) begin
                        q_reg[k]       <= q_next[k];
                        r_reg[k]       <= wrap[k] ? N_W'(rs[k] - {1'b0, n_reg})
                                                  : rs[k][N_W-1:0];
                        out_pos_reg[k] <= neg_reg[k] ? base_reg[k] - q_next[k]
                                                     : base_reg[k] + q_next[k];
                        out_vel_reg[k] <= vel_reg[k];
                        // only the first point sees a change of velocity
                        out_acc_reg[k] <= (i_reg == '0) ? acc_reg[k] : '0;
                    end
                    prev_reg     <= vel_reg;
                    out_last_reg <= i_next == count_reg;
                    i_reg        <= i_next;
                end
                default: ;
            endcase
        end
    end

    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sqrt_done;
    assign stat.short_seg = {len_reg, 1'b0} < (LEN_W + 1)'(step_reg);
    assign stat.more      = i_reg != count_reg;

    assign m_pos_x       = out_pos_reg[0];
    assign m_pos_y       = out_pos_reg[1];
    assign m_pos_z       = out_pos_reg[2];
    assign m_vel_x       = out_vel_reg[0];
    assign m_vel_y       = out_vel_reg[1];
    assign m_vel_z       = out_vel_reg[2];
    assign m_acc_x       = out_acc_reg[0];
    assign m_acc_y       = out_acc_reg[1];
    assign m_acc_z       = out_acc_reg[2];
    assign m_last_of_run = out_last_reg;

endmodule

@@ sv/lpi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpi_ctrl
// sequencer: steps the datapath through square root, divisions and
// multiplications for a waypoint, then hands out the points one by one
// ----------------------------------------------------------------------------
module lpi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_op,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output lpi_pkg::dp_cmd_t   cmd,
    input  lpi_pkg::dp_stat_t  stat
);
    import lpi_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_LSET,
        ST_LCHK,
        ST_NDIV_GO,
        ST_NDIV_WAIT,
        ST_NSET,
        ST_PDIV_GO,
        ST_PDIV_WAIT,
        ST_PSET,
        ST_VMUL,
        ST_VMUL2,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_VSET,
        ST_AMUL,
        ST_AMUL2,
        ST_AMUL3,
        ST_ADIV_GO,
        ST_ADIV_WAIT,
        ST_ASET,
        ST_EMIT_CHK,
        ST_OUT_WAIT
    } state_t;

    state_t     state_reg;
    logic [1:0] ax_reg;

    always_comb begin
        cmd.axis = ax_reg;
        case (state_reg)
            ST_IDLE:     cmd.op = s_valid ? (s_op ? DP_LOAD : DP_START) : DP_NOP;
            ST_SQ:       cmd.op = DP_SQ;
            ST_SQRT_GO:  cmd.op = DP_SQRT;
            ST_LSET:     cmd.op = DP_LSET;
            ST_NDIV_GO:  cmd.op = DP_NDIV;
            ST_NSET:     cmd.op = DP_NSET;
            ST_PDIV_GO:  cmd.op = DP_PDIV;
            ST_PSET:     cmd.op = DP_PSET;
            ST_VMUL:     cmd.op = DP_VMUL;
            ST_VMUL2:    cmd.op = DP_VMUL2;
            ST_VDIV_GO:  cmd.op = DP_XDIV;
            ST_VSET:     cmd.op = DP_VSET;
            ST_AMUL:     cmd.op = DP_AMUL;
            ST_AMUL2:    cmd.op = DP_AMUL2;
            ST_AMUL3:    cmd.op = DP_AMUL3;
            ST_ADIV_GO:  cmd.op = DP_XDIV;
            ST_ASET:     cmd.op = DP_ASET;
            ST_EMIT_CHK: cmd.op = stat.more ? DP_EMIT : DP_NOP;
            default:     cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ax_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    ax_reg <= '0;
                    if (s_valid) begin
                        state_reg <= s_op ? ST_SQ : ST_OUT_WAIT;
                    end
                end
                ST_SQ: begin
                    if (ax_reg == 2'd2) begin
                        ax_reg    <= '0;
                        state_reg <= ST_SQRT_GO;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                ST_SQRT_GO:   state_reg <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: if (stat.sqrt_done) state_reg <= ST_LSET;
                ST_LSET:      state_reg <= ST_LCHK;
                ST_LCHK:      state_reg <= stat.short_seg ? ST_IDLE : ST_NDIV_GO;
                ST_NDIV_GO:   state_reg <= ST_NDIV_WAIT;
                ST_NDIV_WAIT: if (stat.div_done) state_reg <= ST_NSET;
                ST_NSET:      state_reg <= ST_PDIV_GO;
                ST_PDIV_GO:   state_reg <= ST_PDIV_WAIT;
                ST_PDIV_WAIT: if (stat.div_done) state_reg <= ST_PSET;
                ST_PSET:      state_reg <= ST_VMUL;
                ST_VMUL:      state_reg <= ST_VMUL2;
                ST_VMUL2:     state_reg <= ST_VDIV_GO;
                ST_VDIV_GO:   state_reg <= ST_VDIV_WAIT;
                ST_VDIV_WAIT: if (stat.div_done) state_reg <= ST_VSET;
                ST_VSET:      state_reg <= ST_AMUL;
                ST_AMUL:      state_reg <= ST_AMUL2;
                ST_AMUL2:     state_reg <= ST_AMUL3;
                ST_AMUL3:     state_reg <= ST_ADIV_GO;
                ST_ADIV_GO:   state_reg <= ST_ADIV_WAIT;
                ST_ADIV_WAIT: if (stat.div_done) state_reg <= ST_ASET;
                ST_ASET: begin
                    if (ax_reg == 2'd2) begin
                        state_reg <= ST_EMIT_CHK;
                    end else begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_PDIV_GO;
                    end
                end
                ST_EMIT_CHK: state_reg <= stat.more ? ST_OUT_WAIT : ST_IDLE;
                ST_OUT_WAIT: if (m_ready) state_reg <= ST_EMIT_CHK;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT_WAIT;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a word is pending");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_NDIV_WAIT || state_reg == ST_PDIV_WAIT ||
                           state_reg == ST_VDIV_WAIT || state_reg == ST_ADIV_WAIT))
        else $error("divider finished outside a wait state");

    a_sqrt_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.sqrt_done |-> state_reg == ST_SQRT_WAIT)
        else $error("square root finished outside its wait state");

    a_last_word_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_CHK && !stat.more) |=> state_reg == ST_IDLE)
        else $error("run ended without returning to idle");

endmodule

@@ sv/linear_path_interpolator.sv @@
// ----------------------------------------------------------------------------
// linear_path_interpolator
// splits straight 3d segments into equal steps with velocity and acceleration
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  s_       | s_valid / s_ready  | op, target x/y/z, double_step, drop_final
//  m_       | m_valid / m_ready  | pos, vel, acc x/y/z, last_of_run
//  cfg_     | cfg_we             | cfg_idx, cfg_wdata
//
//  a start word gives its one result in the cycle after acceptance
//  a move steps through the one-bit-per-cycle divider, shared by step count,
//  positions, velocity and acceleration, then hands out its points one at a
//  time, each held until m_ready
//  s_ready is high only while idle; reset is synchronous and needs no sweep
// ----------------------------------------------------------------------------
module linear_path_interpolator #(
    parameter int MAX_STEPS = lpi_pkg::MAX_STEPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [lpi_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_x,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_y,
    input  logic signed [lpi_pkg::COORD_W-1:0]   s_target_z,
    input  logic                                 s_double_step,
    input  logic                                 s_drop_final,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_x,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_y,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_pos_z,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_x,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_y,
    output logic signed [lpi_pkg::COORD_W-1:0]   m_vel_z,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_x,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_y,
    output logic signed [lpi_pkg::ACC_W-1:0]     m_acc_z,
    output logic                                 m_last_of_run
);
    import lpi_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    lpi_datapath #(.MAX_STEPS(MAX_STEPS)) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_target_x    (s_target_x),
        .s_target_y    (s_target_y),
        .s_target_z    (s_target_z),
        .s_double_step (s_double_step),
        .s_drop_final  (s_drop_final),
        .cmd           (cmd),
        .stat          (stat),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_z       (m_pos_z),
        .m_vel_x       (m_vel_x),
        .m_vel_y       (m_vel_y),
        .m_vel_z       (m_vel_z),
        .m_acc_x       (m_acc_x),
        .m_acc_y       (m_acc_y),
        .m_acc_z       (m_acc_z),
        .m_last_of_run (m_last_of_run)
    );

endmodule
